>>> rtl/fbec_pkg.sv
package fbec_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned TOT_W        = 8;
  localparam int unsigned POP_W        = $clog2(WORD_W) + 1;

  localparam int unsigned FAULT_BITS_DEFAULT = 32;
  localparam int unsigned NARROW_BITS  = 16;
  localparam int unsigned EXCLUDED_BIT = 15;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(99);
  localparam logic [TOT_W-1:0] TOTAL_MAX = TOT_W'(255);

  typedef logic [WORD_W-1:0] fault_word_t;
  typedef logic [IDX_W-1:0]  read_index_t;
  typedef logic [CNT_W-1:0]  event_count_t;
  typedef logic [TOT_W-1:0]  active_total_t;

endpackage

>>> rtl/fbec_in_if.sv
interface fbec_in_if
  import fbec_pkg::*;
();
  logic        valid;
  logic        ready;
  fault_word_t fault_word;
  read_index_t read_index;
  logic        clear_total;

  modport source (output valid, fault_word, read_index, clear_total, input ready);
  modport sink   (input valid, fault_word, read_index, clear_total, output ready);
endinterface

>>> rtl/fbec_out_if.sv
interface fbec_out_if
  import fbec_pkg::*;
();
  logic          valid;
  logic          ready;
  fault_word_t   rising_mask;
  active_total_t active_total;
  event_count_t  selected_count;

  modport source (output valid, rising_mask, active_total, selected_count, input ready);
  modport sink   (input valid, rising_mask, active_total, selected_count, output ready);
endinterface

>>> rtl/fbec_counters.sv
module fbec_counters
  import fbec_pkg::*;
#(
  parameter int unsigned FAULT_BITS = FAULT_BITS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         upd_i,
  input  logic         wide_mode_i,
  input  fault_word_t  fault_word_i,
  input  read_index_t  read_index_i,
  output fault_word_t  rising_mask_o,
  output fault_word_t  active_o,
  output event_count_t selected_count_o
);

  localparam int unsigned CIW = $clog2(FAULT_BITS);
  localparam fault_word_t WIDE_MASK   = WORD_W'((64'd1 << FAULT_BITS) - 64'd1);
  localparam fault_word_t NARROW_MASK = WORD_W'((64'd1 << NARROW_BITS) - 64'd1);
  localparam fault_word_t EXCL_MASK   = ~(WORD_W'(1) << EXCLUDED_BIT);

  fault_word_t  prev_q;
  fault_word_t  mask;
  fault_word_t  rising;
  event_count_t cnt_q [FAULT_BITS];
  event_count_t cnt_d [FAULT_BITS];

  assign mask   = wide_mode_i ? WIDE_MASK : NARROW_MASK;
  assign rising = fault_word_i & ~prev_q & mask;

  assign rising_mask_o = rising;
  assign active_o      = fault_word_i & mask & EXCL_MASK;

  always_comb begin
    for (int i = 0; i < FAULT_BITS; i++) begin
      if (rising[i] && (cnt_q[i] != COUNT_MAX)) begin
        cnt_d[i] = cnt_q[i] + CNT_W'(1);
      end else begin
        cnt_d[i] = cnt_q[i];
      end
    end
  end

  // indices at or past FAULT_BITS have no counter, so they read as zero
  always_comb begin
    if ({1'b0, read_index_i} < (IDX_W + 1)'(FAULT_BITS)) begin
      selected_count_o = cnt_d[read_index_i[CIW-1:0]];
    end else begin
      selected_count_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      for (int i = 0; i < FAULT_BITS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_i) begin
      prev_q <= fault_word_i;
      for (int i = 0; i < FAULT_BITS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

>>> rtl/fbec_total.sv
module fbec_total
  import fbec_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_i,
  input  logic          clear_i,
  input  fault_word_t   active_i,
  output active_total_t total_o
);

  active_total_t    total_q;
  logic [POP_W-1:0] pop;
  logic [TOT_W:0]   sum;

  assign pop = POP_W'($countones(active_i));
  assign sum = {1'b0, (clear_i ? '0 : total_q)} + (TOT_W + 1)'(pop);

  // saturating add, result is the total after this transfer
  assign total_o = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (upd_i) begin
      total_q <= total_o;
    end
  end

endmodule

>>> rtl/fault_bit_event_counter.sv
// Fault bit event counter.
// Input channel in_i carries one fault word, a counter index and a clear flag
// per transfer; output channel out_o returns one result per input: the mask
// of examined bits that rose since the previous word, the saturating active
// total (bit 15 excluded) and the event counter named by read_index.
// cfg_we_i / cfg_wdata_i write wide_mode: 0 examines bits 0..15, 1 examines
// bits 0..FAULT_BITS-1. Write it only while no item is in flight.
// A result passes the input register, then the result register, before it can
// transfer on out_o; the counter and total logic sits between the two registers.
// Throughput: one item per cycle while out_o is not stalled; the counter bank,
// popcount and saturating adders are all combinational.
// A full result register holds while out_o.ready is low; the input register
// still takes one more item, after which in_i.ready drops until out_o moves.
// Reset clears the previous word, all event counters, the total, wide_mode
// and both valid flags; in_i.ready is high once reset is released.
module fault_bit_event_counter
  import fbec_pkg::*;
#(
  parameter int unsigned FAULT_BITS = FAULT_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  fbec_in_if.sink    in_i,
  fbec_out_if.source out_o
);

  logic          wide_mode_q;
  logic          s1_valid_q;
  fault_word_t   s1_word_q;
  read_index_t   s1_idx_q;
  logic          s1_clr_q;
  logic          out_valid_q;
  fault_word_t   rising_q;
  active_total_t total_q;
  event_count_t  sel_q;

  logic          adv;
  fault_word_t   rising;
  fault_word_t   active;
  active_total_t total;
  event_count_t  sel;

  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      wide_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_word_q <= in_i.fault_word;
      s1_idx_q  <= in_i.read_index;
      s1_clr_q  <= in_i.clear_total;
    end
  end

  fbec_counters #(
    .FAULT_BITS(FAULT_BITS)
  ) u_counters (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_i           (adv),
    .wide_mode_i     (wide_mode_q),
    .fault_word_i    (s1_word_q),
    .read_index_i    (s1_idx_q),
    .rising_mask_o   (rising),
    .active_o        (active),
    .selected_count_o(sel)
  );

  fbec_total u_total (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .clear_i (s1_clr_q),
    .active_i(active),
    .total_o (total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rising_q <= rising;
      total_q  <= total;
      sel_q    <= sel;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.rising_mask    = rising_q;
  assign out_o.active_total   = total_q;
  assign out_o.selected_count = sel_q;

endmodule

>>> sim/testbench.sv
module testbench;
  import fbec_pkg::*;

  localparam int unsigned FBITS         = FAULT_BITS_DEFAULT;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 258;
  localparam int          NUM_PHASES    = 4;
  localparam int          DRAIN_AT      = 128;
  localparam int          SETTLE_CYCLES = 4;

  typedef struct packed {
    fault_word_t   rising;
    active_total_t total;
    event_count_t  count;
  } fault_result_t;

  typedef struct packed {
    bit            mode_wr;
    bit            mode_val;
    fault_word_t   word;
    read_index_t   idx;
    logic          clr;
    bit            typed;
    fault_result_t res;
  } stim_row_t;

  localparam fault_result_t NO_RES = '0;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  fbec_in_if  in_ch ();
  fbec_out_if out_ch ();

  fault_bit_event_counter #(
    .FAULT_BITS (FBITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  fault_word_t   last_word;
  event_count_t  bit_events [32];
  active_total_t fault_total;
  bit            wide_sel;

  fault_result_t pending_results [$];
  int            errors      = 0;
  int            cycles      = 0;
  bit            idle_on     = 1'b1;
  int            hold_cycles = 0;

  // typed rows: narrow mode straight after reset, easy to follow by hand
  stim_row_t directed_rows [19] = '{
    '{1'b1, 1'b0, 32'h0000_0000, 5'd0,  1'b0, 1'b1, '{32'h0000_0000, 8'd0,  7'd0}},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 5'd0,  1'b0, 1'b1, '{32'h0000_FFFF, 8'd15, 7'd1}},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 5'd16, 1'b0, 1'b1, '{32'h0000_0000, 8'd30, 7'd0}},
    '{1'b0, 1'b0, 32'h0000_0000, 5'd31, 1'b1, 1'b1, '{32'h0000_0000, 8'd0,  7'd0}},
    '{1'b0, 1'b0, 32'h0000_8000, 5'd15, 1'b0, 1'b1, '{32'h0000_8000, 8'd0,  7'd2}},
    '{1'b0, 1'b0, 32'h0000_0001, 5'd0,  1'b0, 1'b1, '{32'h0000_0001, 8'd1,  7'd2}},
    '{1'b0, 1'b0, 32'h5555_AAAA, 5'd3,  1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'hAAAA_5555, 5'd4,  1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'hFFFF_0000, 5'd16, 1'b0, 1'b0, NO_RES},
    // upper bits already stored while unexamined
    '{1'b1, 1'b1, 32'hFFFF_0000, 5'd16, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 5'd31, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'h0000_0000, 5'd5,  1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 5'd31, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 5'd30, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'h8000_0000, 5'd31, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'h0000_8000, 5'd15, 1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'h7FFF_7FFF, 5'd14, 1'b0, 1'b0, NO_RES},
    // back to narrow: upper bits no longer count
    '{1'b1, 1'b0, 32'hFFFF_FFFF, 5'd20, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 32'h0000_0000, 5'd17, 1'b1, 1'b0, NO_RES}
  };

  function automatic fault_result_t count_fault_events(input fault_word_t word,
                                                       input read_index_t idx,
                                                       input logic clr);
    fault_word_t   mask;
    fault_word_t   rise;
    fault_word_t   act;
    active_total_t tot;
    fault_result_t res;
    mask = wide_sel ? fault_word_t'((64'd1 << FBITS) - 64'd1)
                    : fault_word_t'((64'd1 << NARROW_BITS) - 64'd1);
    rise = word & ~last_word & mask;
    act  = word & mask;
    act[EXCLUDED_BIT] = 1'b0;
    tot  = clr ? '0 : fault_total;
    for (int i = 0; i < 32; i++) begin
      if (rise[i] && bit_events[i] < COUNT_MAX) begin
        bit_events[i] = bit_events[i] + 1'b1;
      end
      if (act[i] && tot < TOTAL_MAX) begin
        tot = tot + 1'b1;
      end
    end
    fault_total = tot;
    last_word   = word;
    res.rising  = rise;
    res.total   = tot;
    res.count   = bit_events[idx];
    return res;
  endfunction

  function automatic fault_word_t pick_fault_word(input fault_word_t prev);
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return fault_word_t'(1) << $urandom_range(0, 31);
      end
      3: begin
        return ~prev;
      end
      4, 5, 6: begin
        // sparse flips keep most bits steady so edges stay rare
        return prev ^ ($urandom & $urandom & $urandom);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_fault_item(input fault_word_t word, input read_index_t idx,
                                 input logic clr, input bit typed,
                                 input fault_result_t typed_res);
    int gap;
    fault_result_t res;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.fault_word  <= word;
    in_ch.read_index  <= idx;
    in_ch.clear_total <= clr;
    do @(posedge clk_i); while (!in_ch.ready);
    res = count_fault_events(word, idx, clr);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit wide);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wide;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wide_sel = wide;
  endtask

  // result side: compare each transfer, then draw the next stall
  always @(posedge clk_i) begin
    fault_result_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.rising_mask !== exp_r.rising) begin
          $error("rising_mask: expected %h, got %h", exp_r.rising, out_ch.rising_mask);
          errors++;
        end
        if (out_ch.active_total !== exp_r.total) begin
          $error("active_total: expected %0d, got %0d", exp_r.total, out_ch.active_total);
          errors++;
        end
        if (out_ch.selected_count !== exp_r.count) begin
          $error("selected_count: expected %0d, got %0d", exp_r.count,
                 out_ch.selected_count);
          errors++;
        end
      end
      hold_cycles = idle_on ? $urandom_range(0, 10) : 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
    end
    out_ch.ready <= (hold_cycles == 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("fault_bit_event_counter test failed");
      $finish;
    end
  end

  initial begin
    fault_word_t word;
    in_ch.valid       <= 1'b0;
    in_ch.fault_word  <= '0;
    in_ch.read_index  <= '0;
    in_ch.clear_total <= 1'b0;
    last_word   = '0;
    fault_total = '0;
    wide_sel    = 1'b0;
    foreach (bit_events[i]) bit_events[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].mode_wr) begin
        set_mode(directed_rows[r].mode_val);
      end
      send_fault_item(directed_rows[r].word, directed_rows[r].idx, directed_rows[r].clr,
                      directed_rows[r].typed, directed_rows[r].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(p % 2 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) begin
          idle_on = ~idle_on;
        end
        if (n == DRAIN_AT) begin
          wait_drained();
        end
        word = pick_fault_word(last_word);
        send_fault_item(word, read_index_t'($urandom_range(0, 31)),
                        ($urandom_range(0, 15) == 0), 1'b0, NO_RES);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("fault_bit_event_counter test passed");
    end else begin
      $display("fault_bit_event_counter test failed");
    end
    $finish;
  end

endmodule
